[sv/bus_address_wildcard_match_core_assert.svh]
// Assertion macros used by the checker of the address matcher.
// Depends on nothing; the including module must have clk and rst in scope.
`ifndef BUS_ADDRESS_WILDCARD_MATCH_CORE_ASSERT_SVH
`define BUS_ADDRESS_WILDCARD_MATCH_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define BAWM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BAWM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/bawm_pkg.sv]
// Package of the bus address wildcard matcher: status codes, register
// indexes, lengths, the register set type and the unit test function.
package bawm_pkg;

  localparam int USER_CODE_BYTES = 6;
  localparam int LEN_W           = 4;
  localparam int DATA_W          = 64;
  localparam int UC_W            = 48;
  localparam int BYTE_W          = 8;
  localparam int UNIT_W          = 24;

  localparam logic [LEN_W-1:0] LEN_BCAST     = LEN_W'(0);
  localparam logic [LEN_W-1:0] LEN_SHORT     = LEN_W'(1);
  localparam logic [LEN_W-1:0] LEN_USER_CODE = LEN_W'(USER_CODE_BYTES);
  localparam logic [LEN_W-1:0] LEN_ID        = LEN_W'(9);

  localparam logic [UNIT_W-1:0] MASK_BYTE = 24'h0000FF;
  localparam logic [UNIT_W-1:0] MASK_HI   = 24'h0000F0;
  localparam logic [UNIT_W-1:0] MASK_LO   = 24'h00000F;
  localparam logic [UNIT_W-1:0] MASK_HEAD = 24'hFFFFFF;

  typedef enum logic [1:0] {
    ST_EXACT   = 2'd0,
    ST_WILD    = 2'd1,
    ST_FAIL    = 2'd2,
    ST_UC_FAIL = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_SHORT_ADDR = 2'd0,
    CFG_USER_CODE  = 2'd1,
    CFG_ID_HEAD    = 2'd2,
    CFG_ID_TAIL    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [BYTE_W-1:0] short_addr;
    logic [UC_W-1:0]   user_code;
    logic [DATA_W-1:0] id_head;
    logic [BYTE_W-1:0] id_tail;
  } own_cfg_t;

  // A unit is exact when the masked bits agree, wild when every masked
  // received bit is one, and a failure otherwise.
  function automatic status_t unit_check(input logic [UNIT_W-1:0] r,
                                         input logic [UNIT_W-1:0] o,
                                         input logic [UNIT_W-1:0] m);
    status_t st;
    if (((r ^ o) & m) == '0) begin
      st = ST_EXACT;
    end else if ((r & m) == m) begin
      st = ST_WILD;
    end else begin
      st = ST_FAIL;
    end
    return st;
  endfunction

  function automatic logic [UNIT_W-1:0] ext_byte(input logic [BYTE_W-1:0] b);
    return {{(UNIT_W-BYTE_W){1'b0}}, b};
  endfunction

endpackage

[sv/bawm_cfg_regs.sv]
// Register set of the matcher: holds the node's own addresses.
// Depends on bawm_pkg.
module bawm_cfg_regs
  import bawm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [DATA_W-1:0] cfg_data,
  output own_cfg_t          own
);

  always_ff @(posedge clk) begin
    if (rst) begin
      own <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SHORT_ADDR: own.short_addr <= cfg_data[BYTE_W-1:0];
        CFG_USER_CODE:  own.user_code  <= cfg_data[UC_W-1:0];
        CFG_ID_HEAD:    own.id_head    <= cfg_data;
        CFG_ID_TAIL:    own.id_tail    <= cfg_data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[sv/bawm_match.sv]
// Match logic of the matcher: one received address against the own addresses.
// Purely combinational; depends on bawm_pkg.
module bawm_match
  import bawm_pkg::*;
(
  input  logic [LEN_W-1:0]  addr_length,
  input  logic [DATA_W-1:0] recv_head,
  input  logic [BYTE_W-1:0] recv_tail,
  input  logic              user_code_flag,
  input  own_cfg_t          own,
  output status_t           status
);

  // Bytes of the own user code above the register width read as zero.
  logic [DATA_W-1:0] own_uc64;
  status_t           uc_a;
  status_t           uc_b;
  logic              uc_fail;
  logic              uc_wild;
  status_t           uc_st;
  status_t           u [10];
  logic              id_fail;
  logic              id_wild;
  status_t           id_st;
  status_t           short_st;

  assign own_uc64 = {{(DATA_W-UC_W){1'b0}}, own.user_code};

  always_comb begin
    uc_fail = 1'b0;
    uc_wild = 1'b0;
    uc_a    = ST_EXACT;
    uc_b    = ST_EXACT;
    for (int i = 0; i < USER_CODE_BYTES; i++) begin
      if (i == 0) begin
        uc_a = unit_check(ext_byte(recv_head[DATA_W-1 -: BYTE_W]),
                          ext_byte(own_uc64[BYTE_W*(USER_CODE_BYTES-1) +: BYTE_W]),
                          MASK_BYTE);
        uc_b = ST_EXACT;
      end else begin
        uc_a = unit_check(ext_byte(recv_head[DATA_W-1-BYTE_W*i -: BYTE_W]),
                          ext_byte(own_uc64[BYTE_W*(USER_CODE_BYTES-1-i) +: BYTE_W]),
                          MASK_HI);
        uc_b = unit_check(ext_byte(recv_head[DATA_W-1-BYTE_W*i -: BYTE_W]),
                          ext_byte(own_uc64[BYTE_W*(USER_CODE_BYTES-1-i) +: BYTE_W]),
                          MASK_LO);
      end
      uc_fail = uc_fail | (uc_a == ST_FAIL) | (uc_b == ST_FAIL);
      uc_wild = uc_wild | (uc_a == ST_WILD) | (uc_b == ST_WILD);
    end
    if (uc_fail) begin
      uc_st = user_code_flag ? ST_UC_FAIL : ST_FAIL;
    end else begin
      uc_st = uc_wild ? ST_WILD : ST_EXACT;
    end
  end

  // Node ID units: bytes 0..2 as one unit, then bytes and nibbles.
  assign u[0] = unit_check(recv_head[63:40], own.id_head[63:40], MASK_HEAD);
  assign u[1] = unit_check(ext_byte(recv_head[39:32]), ext_byte(own.id_head[39:32]), MASK_BYTE);
  assign u[2] = unit_check(ext_byte(recv_head[31:24]), ext_byte(own.id_head[31:24]), MASK_LO);
  assign u[3] = unit_check(ext_byte(recv_head[31:24]), ext_byte(own.id_head[31:24]), MASK_HI);
  assign u[4] = unit_check(ext_byte(recv_head[23:16]), ext_byte(own.id_head[23:16]), MASK_LO);
  assign u[5] = unit_check(ext_byte(recv_head[23:16]), ext_byte(own.id_head[23:16]), MASK_HI);
  assign u[6] = unit_check(ext_byte(recv_head[15:8]), ext_byte(own.id_head[15:8]), MASK_BYTE);
  assign u[7] = unit_check(ext_byte(recv_head[7:0]), ext_byte(own.id_head[7:0]), MASK_LO);
  assign u[8] = unit_check(ext_byte(recv_head[7:0]), ext_byte(own.id_head[7:0]), MASK_HI);
  assign u[9] = unit_check(ext_byte(recv_tail), ext_byte(own.id_tail), MASK_BYTE);

  always_comb begin
    id_fail = 1'b0;
    id_wild = 1'b0;
    for (int k = 0; k < 10; k++) begin
      id_fail = id_fail | (u[k] == ST_FAIL);
      id_wild = id_wild | (u[k] == ST_WILD);
    end
    // Units 1 and 2, 3 and 4, 5 through 7, and 8 and 9 must each agree.
    if (id_fail || (u[1] != u[2]) || (u[3] != u[4]) || (u[5] != u[6]) ||
        (u[6] != u[7]) || (u[8] != u[9])) begin
      id_st = ST_FAIL;
    end else begin
      id_st = id_wild ? ST_WILD : ST_EXACT;
    end
  end

  assign short_st = unit_check(ext_byte(recv_head[DATA_W-1 -: BYTE_W]),
                               ext_byte(own.short_addr), MASK_BYTE);

  always_comb begin
    if (addr_length == LEN_SHORT) begin
      status = short_st;
    end else if (addr_length == LEN_USER_CODE) begin
      status = uc_st;
    end else if (addr_length == LEN_ID) begin
      status = id_st;
    end else if (addr_length == LEN_BCAST) begin
      status = ST_WILD;
    end else begin
      status = ST_FAIL;
    end
  end

endmodule

[sv/bus_address_wildcard_match_core.sv]
// Top level of the bus address wildcard matcher.
// Depends on bawm_pkg, bawm_cfg_regs and bawm_match.
//
// The matcher takes one received address item per clock cycle unless
// item_stall is high and returns one status per item, in order: the item is
// held in an input register, matched by shallow compare logic, and the
// status is held in a result register. A stall on the result side backs up
// through both registers, so up to two items can be in flight. The user must
// write own addresses through cfg only while idle; the block does not check.
module bus_address_wildcard_match_core
  import bawm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [DATA_W-1:0] cfg_data,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic [LEN_W-1:0]  addr_length,
  input  logic [DATA_W-1:0] recv_head,
  input  logic [BYTE_W-1:0] recv_tail,
  input  logic              user_code_flag,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [1:0]        match_status
);

  own_cfg_t          own;
  logic              in_full;
  logic [LEN_W-1:0]  in_length;
  logic [DATA_W-1:0] in_head;
  logic [BYTE_W-1:0] in_tail;
  logic              in_flag;
  status_t           status;
  status_t           out_status;
  logic              adv_out;
  logic              adv_in;

  bawm_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .own       (own)
  );

  bawm_match u_match (
    .addr_length    (in_length),
    .recv_head      (in_head),
    .recv_tail      (in_tail),
    .user_code_flag (in_flag),
    .own            (own),
    .status         (status)
  );

  assign adv_out    = !result_valid || !result_stall;
  assign adv_in     = !in_full || adv_out;
  assign item_stall = !adv_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (adv_in) begin
      in_full <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_in && item_valid) begin
      in_length <= addr_length;
      in_head   <= recv_head;
      in_tail   <= recv_tail;
      in_flag   <= user_code_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv_out) begin
      result_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && in_full) begin
      out_status <= status;
    end
  end

  assign match_status = out_status;

endmodule

[sv/bawm_checker.sv]
// Port-level checker of the address matcher and its bind to the top level.
// Depends on bawm_pkg and bus_address_wildcard_match_core_assert.svh.
`include "bus_address_wildcard_match_core_assert.svh"

module bawm_checker
  import bawm_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input logic [LEN_W-1:0]  addr_length,
  input logic              user_code_flag,
  input logic              result_valid,
  input logic              result_stall,
  input logic [1:0]        match_status
);

  logic item_acc;
  logic bad_len;

  assign item_acc = item_valid && !item_stall;
  assign bad_len  = (addr_length != LEN_BCAST) && (addr_length != LEN_SHORT) &&
                    (addr_length != LEN_USER_CODE) && (addr_length != LEN_ID);

  `BAWM_ASSERT_NEXT(a_result_held, result_valid && result_stall,
    result_valid && $stable(match_status), "stalled result changed")

  // An accepted item, with the result side then free, moves to the result.
  `BAWM_ASSERT_NEXT(a_bcast_wild,
    (item_acc && addr_length == LEN_BCAST) ##1 !result_stall,
    result_valid && match_status == ST_WILD,
    "broadcast item did not give a wildcard match")

  `BAWM_ASSERT_NEXT(a_bad_len_fail, (item_acc && bad_len) ##1 !result_stall,
    result_valid && match_status == ST_FAIL,
    "item of unknown length did not fail")

  `BAWM_ASSERT_NEXT(a_uc_fail_flag, (item_acc && !user_code_flag) ##1 !result_stall,
    match_status != ST_UC_FAIL,
    "user-code failure without the flag")

endmodule

bind bus_address_wildcard_match_core bawm_checker u_bawm_checker (.*);
